// ===== hw/rtl/spatial_hash_neighbour_search_top_assert.svh =====
// assertion macros for the neighbour search block
`ifndef SPATIAL_HASH_NEIGHBOUR_SEARCH_TOP_ASSERT_SVH
`define SPATIAL_HASH_NEIGHBOUR_SEARCH_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SHNS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// signal holds while an item is stalled
`define SHNS_ASSERT_HOLD(lbl, clk, rst, vld, rdy, sig) \
   lbl: assert property (@(posedge clk) disable iff (rst) (vld && !rdy) |=> $stable(sig)) \
      else $error("stalled item changed");

`endif

// ===== hw/rtl/shns_pkg.sv =====
// shared types and constants of the neighbour search block
`default_nettype none

package shns_pkg;

   localparam int COORD_W    = 32;
   localparam int SCALE_W    = 24;
   localparam int PROD_W     = 56;
   localparam int IDX_W      = 10;
   localparam int IN_DATA_W  = 112;
   localparam int IN_USER_W  = 2;
   localparam int OUT_DATA_W = 16;
   localparam int OUT_USER_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0]         REG_CELL_SCALE = 1'b0;
   localparam logic [SCALE_W-1:0] SCALE_RESET    = 24'd65536;

   localparam logic [31:0] HASH_MUL_X = 32'd73856093;
   localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
   localparam logic [31:0] HASH_MUL_Z = 32'd83492791;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_IGNORE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_STORE_FULL  = 3'd1,
      ST_TABLE_FULL  = 3'd2,
      ST_BAD_INDEX   = 3'd3,
      ST_TRUNCATED   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_RES,
      EMIT_EMPTY,
      EMIT_PEND_MID,
      EMIT_PEND_LAST,
      EMIT_PEND_CUT
   } emit_type;

   typedef enum logic [4:0] {
      S_RST_SWEEP,
      S_IDLE,
      S_INS_CHK,
      S_INS_MUL,
      S_INS_KEY,
      S_HASH,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_RESP,
      S_CLR_SWEEP,
      S_Q_CHK,
      S_Q_BASE,
      S_Q_NKEY,
      S_WALK_CHK,
      S_WALK_RD,
      S_NEXT_CELL,
      S_Q_FIN
   } state_type;

   typedef struct packed {
      logic       load_in;
      logic       mul_en;
      logic       key_en;
      logic       hash_en;
      logic       probe_next;
      logic       tab_rd;
      logic       tab_clr;
      logic       ins_commit;
      logic       set_res;
      logic       res_found;
      status_type res_status;
      logic       pt_rd;
      logic       base_en;
      logic       cell_next;
      logic       nkey_en;
      logic       node_head;
      logic       link_rd;
      logic       node_link;
      logic       pend_load;
      logic       count_clear;
      emit_type   emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic     in_valid;
      mode_type in_mode;
      logic     is_query;
      logic     store_full;
      logic     bad_index;
      logic     tab_valid;
      logic     tab_match;
      logic     probe_last;
      logic     axis_last;
      logic     cell_last;
      logic     node_end;
      logic     node_is_q;
      logic     n_zero;
      logic     n_full;
      logic     out_free;
      logic     sweep_last;
   } ctrl_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/shns_csr.sv =====
// configuration register port
`default_nettype none

module shns_csr
   import shns_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [SCALE_W-1:0]    cell_scale
);

   logic [SCALE_W-1:0] cell_scale_ff;
   logic [SCALE_W-1:0] cell_scale_in;
   logic               sel_scale;

   assign sel_scale = (csr_paddr[CSR_ADDR_W-1:2] == REG_CELL_SCALE);

   always_comb begin
      cell_scale_in = cell_scale_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_scale) begin
         cell_scale_in = csr_pwdata[SCALE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_scale_ff <= SCALE_RESET;
      end else begin
         cell_scale_ff <= cell_scale_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_scale ? CSR_DATA_W'(cell_scale_ff) : '0;
   assign cell_scale = cell_scale_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/shns_ctrl.sv =====
// sequencer for insert, probe, list walk and clear
`default_nettype none

module shns_ctrl
   import shns_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_stat_type stat,
   output ctrl_cmd_type       cmd,
   output logic               req_tready
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_RST_SWEEP: begin
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (stat.in_valid) begin
               unique case (stat.in_mode)
                  MODE_INSERT: state_in = S_INS_CHK;
                  MODE_QUERY:  state_in = S_Q_CHK;
                  MODE_CLEAR:  state_in = S_CLR_SWEEP;
                  MODE_IGNORE: state_in = S_IDLE;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_INS_CHK: state_in = stat.store_full ? S_RESP : S_INS_MUL;
         S_INS_MUL: state_in = S_INS_KEY;
         S_INS_KEY: state_in = stat.axis_last ? S_HASH : S_INS_MUL;
         S_HASH:     state_in = S_PROBE_RD;
         S_PROBE_RD: state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (stat.is_query) begin
               if (!stat.tab_valid) state_in = S_NEXT_CELL;
               else if (stat.tab_match) state_in = S_WALK_CHK;
               else if (stat.probe_last) state_in = S_NEXT_CELL;
               else state_in = S_PROBE_RD;
            end else begin
               if (!stat.tab_valid || stat.tab_match || stat.probe_last) state_in = S_RESP;
               else state_in = S_PROBE_RD;
            end
         end
         S_RESP: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         S_CLR_SWEEP: begin
            if (stat.sweep_last) state_in = S_RESP;
         end
         S_Q_CHK:  state_in = stat.bad_index ? S_RESP : S_Q_BASE;
         S_Q_BASE: state_in = S_Q_NKEY;
         S_Q_NKEY: state_in = S_HASH;
         S_WALK_CHK: begin
            if (stat.node_end) state_in = S_NEXT_CELL;
            else if (stat.node_is_q) state_in = S_WALK_RD;
            else if (stat.n_full) begin
               if (stat.out_free) state_in = S_IDLE;
            end else if (stat.n_zero || stat.out_free) state_in = S_WALK_RD;
         end
         S_WALK_RD:   state_in = S_WALK_CHK;
         S_NEXT_CELL: state_in = stat.cell_last ? S_Q_FIN : S_Q_NKEY;
         S_Q_FIN: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_RST_SWEEP: cmd.tab_clr = 1'b1;
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = stat.in_valid;
            if (stat.in_valid && stat.in_mode == MODE_CLEAR) cmd.count_clear = 1'b1;
         end
         S_INS_CHK: begin
            if (stat.store_full) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_STORE_FULL;
            end
         end
         S_INS_MUL:  cmd.mul_en  = 1'b1;
         S_INS_KEY:  cmd.key_en  = 1'b1;
         S_HASH:     cmd.hash_en = 1'b1;
         S_PROBE_RD: cmd.tab_rd  = 1'b1;
         S_PROBE_CHK: begin
            if (stat.is_query) begin
               if (stat.tab_valid && stat.tab_match) cmd.node_head = 1'b1;
               else if (stat.tab_valid && !stat.probe_last) cmd.probe_next = 1'b1;
            end else begin
               if (!stat.tab_valid || stat.tab_match) begin
                  cmd.ins_commit = 1'b1;
                  cmd.set_res    = 1'b1;
                  cmd.res_found  = 1'b1;
                  cmd.res_status = ST_OK;
               end else if (stat.probe_last) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_TABLE_FULL;
               end else begin
                  cmd.probe_next = 1'b1;
               end
            end
         end
         S_RESP: begin
            if (stat.out_free) cmd.emit = EMIT_RES;
         end
         S_CLR_SWEEP: begin
            cmd.tab_clr = 1'b1;
            if (stat.sweep_last) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_OK;
            end
         end
         S_Q_CHK: begin
            if (stat.bad_index) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_BAD_INDEX;
            end else begin
               cmd.pt_rd = 1'b1;
            end
         end
         S_Q_BASE: cmd.base_en = 1'b1;
         S_Q_NKEY: cmd.nkey_en = 1'b1;
         S_WALK_CHK: begin
            if (!stat.node_end) begin
               if (stat.node_is_q) begin
                  cmd.link_rd = 1'b1;
               end else if (stat.n_full) begin
                  if (stat.out_free) cmd.emit = EMIT_PEND_CUT;
               end else if (stat.n_zero) begin
                  cmd.pend_load = 1'b1;
                  cmd.link_rd   = 1'b1;
               end else if (stat.out_free) begin
                  cmd.emit      = EMIT_PEND_MID;
                  cmd.pend_load = 1'b1;
                  cmd.link_rd   = 1'b1;
               end
            end
         end
         S_WALK_RD: cmd.node_link = 1'b1;
         S_NEXT_CELL: begin
            if (!stat.cell_last) cmd.cell_next = 1'b1;
         end
         S_Q_FIN: begin
            if (stat.out_free) cmd.emit = stat.n_zero ? EMIT_EMPTY : EMIT_PEND_LAST;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/shns_datapath.sv =====
// key arithmetic, point store, cell table, list walk and result register
`default_nettype none

module shns_datapath
   import shns_pkg::*;
#(
   parameter int MAX_POINTS     = 1024,
   parameter int TABLE_SIZE     = 2048,
   parameter int MAX_NEIGHBOURS = 64,
   parameter int KEY_BITS       = 21
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctrl_cmd_type          cmd,
   output ctrl_stat_type              stat,
   input  wire logic [SCALE_W-1:0]    cell_scale,
   input  wire logic                  req_tvalid,
   input  wire logic [IN_DATA_W-1:0]  req_tdata,
   input  wire logic [IN_USER_W-1:0]  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [IDX_W-1:0]      rsp_ref,
   output logic                       rsp_found,
   output logic                       rsp_last,
   output status_type                 rsp_status
);

   localparam int PW  = $clog2(MAX_POINTS);
   localparam int CW  = PW + 1;
   localparam int TW  = $clog2(TABLE_SIZE);
   localparam int NW  = $clog2(MAX_NEIGHBOURS + 1);
   localparam int KW3 = 3 * KEY_BITS;
   localparam logic [CW-1:0] LINK_END = CW'(MAX_POINTS);

   // input item
   mode_type            mode_ff;
   logic [COORD_W-1:0]  cx_ff, cy_ff, cz_ff;
   logic [IDX_W-1:0]    q_ff;

   // key build
   logic [1:0]          axis_ff;
   logic [SCALE_W-1:0]  prod_hi_ff;
   logic                neg_ff;
   logic [KW3-1:0]      key_ff;
   logic [KW3-1:0]      base_ff;
   logic [COORD_W-1:0]  coord_sel;
   logic [COORD_W-1:0]  mag;
   logic [PROD_W-1:0]   prod;
   logic [KEY_BITS-1:0] key_field;

   // probe
   logic [TW-1:0]       addr_ff;
   logic [TW-1:0]       pcnt_ff;
   logic [TW-1:0]       sweep_ff;
   logic [TW-1:0]       hash;
   logic [TW-1:0]       hx, hy, hz;

   // stores
   logic                tab_valid_mem [TABLE_SIZE];
   logic [KW3-1:0]      tab_key_mem   [TABLE_SIZE];
   logic [PW-1:0]       tab_head_mem  [TABLE_SIZE];
   logic [KW3-1:0]      pt_key_mem    [MAX_POINTS];
   logic [CW-1:0]       link_mem      [MAX_POINTS];
   logic                tab_rvalid_ff;
   logic [KW3-1:0]      tab_rkey_ff;
   logic [PW-1:0]       tab_rhead_ff;
   logic [KW3-1:0]      pt_rdata_ff;
   logic [CW-1:0]       link_rdata_ff;
   logic [CW-1:0]       count_ff;

   // walk
   logic [1:0]          dx_ff, dy_ff, dz_ff;
   logic [CW-1:0]       node_ff;
   logic [PW-1:0]       pend_ff;
   logic [NW-1:0]       n_ff;
   logic [KEY_BITS-1:0] nx, ny, nz;

   // result
   logic [IDX_W-1:0]    res_ref_ff;
   logic                res_found_ff;
   status_type          res_status_ff;
   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_ref_ff;
   logic                rsp_found_ff;
   logic                rsp_last_ff;
   status_type          rsp_status_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         mode_ff <= mode_type'(req_tuser);
         cx_ff   <= req_tdata[31:0];
         cy_ff   <= req_tdata[63:32];
         cz_ff   <= req_tdata[95:64];
         q_ff    <= req_tdata[105:96];
      end
   end

   always_comb begin
      case (axis_ff)
         2'd0:    coord_sel = cx_ff;
         2'd1:    coord_sel = cy_ff;
         default: coord_sel = cz_ff;
      endcase
   end

   assign mag  = coord_sel[COORD_W-1] ? (COORD_W'(0) - coord_sel) : coord_sel;
   assign prod = PROD_W'(mag) * PROD_W'(cell_scale);
   assign key_field = neg_ff ? KEY_BITS'(SCALE_W'(0) - prod_hi_ff) : KEY_BITS'(prod_hi_ff);

   assign nx = base_ff[KEY_BITS-1:0] + KEY_BITS'(dx_ff) - KEY_BITS'(1);
   assign ny = base_ff[2*KEY_BITS-1:KEY_BITS] + KEY_BITS'(dy_ff) - KEY_BITS'(1);
   assign nz = base_ff[KW3-1:2*KEY_BITS] + KEY_BITS'(dz_ff) - KEY_BITS'(1);

   // table size is a power of two, so only the low product bits matter
   assign hx   = TW'(TW'(key_ff[KEY_BITS-1:0]) * TW'(HASH_MUL_X));
   assign hy   = TW'(TW'(key_ff[2*KEY_BITS-1:KEY_BITS]) * TW'(HASH_MUL_Y));
   assign hz   = TW'(TW'(key_ff[KW3-1:2*KEY_BITS]) * TW'(HASH_MUL_Z));
   assign hash = hx ^ hy ^ hz;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         axis_ff <= 2'd0;
      end else if (cmd.key_en) begin
         axis_ff <= axis_ff + 2'd1;
      end
      if (cmd.mul_en) begin
         prod_hi_ff <= prod[PROD_W-1:COORD_W];
         neg_ff     <= coord_sel[COORD_W-1];
      end
      if (cmd.key_en) begin
         case (axis_ff)
            2'd0:    key_ff[KEY_BITS-1:0]          <= key_field;
            2'd1:    key_ff[2*KEY_BITS-1:KEY_BITS] <= key_field;
            default: key_ff[KW3-1:2*KEY_BITS]      <= key_field;
         endcase
      end else if (cmd.nkey_en) begin
         key_ff <= {nz, ny, nx};
      end
      if (cmd.hash_en) begin
         addr_ff <= hash;
         pcnt_ff <= '0;
      end else if (cmd.probe_next) begin
         addr_ff <= addr_ff + TW'(1);
         pcnt_ff <= pcnt_ff + TW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.tab_clr) begin
         sweep_ff <= sweep_ff + TW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tab_clr) begin
         tab_valid_mem[sweep_ff] <= 1'b0;
      end else if (cmd.ins_commit) begin
         tab_valid_mem[addr_ff] <= 1'b1;
         tab_key_mem[addr_ff]   <= key_ff;
         tab_head_mem[addr_ff]  <= count_ff[PW-1:0];
      end
      if (cmd.tab_rd) begin
         tab_rvalid_ff <= tab_valid_mem[addr_ff];
         tab_rkey_ff   <= tab_key_mem[addr_ff];
         tab_rhead_ff  <= tab_head_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_commit) begin
         pt_key_mem[count_ff[PW-1:0]] <= key_ff;
         link_mem[count_ff[PW-1:0]]   <= tab_rvalid_ff ? {1'b0, tab_rhead_ff} : LINK_END;
      end
      if (cmd.pt_rd) begin
         pt_rdata_ff <= pt_key_mem[PW'(q_ff)];
      end
      if (cmd.link_rd) begin
         link_rdata_ff <= link_mem[node_ff[PW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.count_clear) begin
         count_ff <= '0;
      end else if (cmd.ins_commit) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.base_en) begin
         base_ff <= pt_rdata_ff;
         dx_ff   <= 2'd0;
         dy_ff   <= 2'd0;
         dz_ff   <= 2'd0;
      end else if (cmd.cell_next) begin
         dx_ff <= (dx_ff == 2'd2) ? 2'd0 : dx_ff + 2'd1;
         if (dx_ff == 2'd2) begin
            dy_ff <= (dy_ff == 2'd2) ? 2'd0 : dy_ff + 2'd1;
            if (dy_ff == 2'd2) dz_ff <= dz_ff + 2'd1;
         end
      end
      if (cmd.node_head) begin
         node_ff <= {1'b0, tab_rhead_ff};
      end else if (cmd.node_link) begin
         node_ff <= link_rdata_ff;
      end
      if (cmd.base_en) begin
         n_ff <= '0;
      end else if (cmd.pend_load) begin
         n_ff <= n_ff + NW'(1);
      end
      if (cmd.pend_load) begin
         pend_ff <= node_ff[PW-1:0];
      end
      if (cmd.set_res) begin
         res_ref_ff    <= cmd.res_found ? IDX_W'(count_ff) : '0;
         res_found_ff  <= cmd.res_found;
         res_status_ff <= cmd.res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.emit)
         EMIT_RES: begin
            rsp_ref_ff    <= res_ref_ff;
            rsp_found_ff  <= res_found_ff;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= res_status_ff;
         end
         EMIT_EMPTY: begin
            rsp_ref_ff    <= '0;
            rsp_found_ff  <= 1'b0;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= ST_OK;
         end
         EMIT_PEND_MID: begin
            rsp_ref_ff    <= IDX_W'(pend_ff);
            rsp_found_ff  <= 1'b1;
            rsp_last_ff   <= 1'b0;
            rsp_status_ff <= ST_OK;
         end
         EMIT_PEND_LAST: begin
            rsp_ref_ff    <= IDX_W'(pend_ff);
            rsp_found_ff  <= 1'b1;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= ST_OK;
         end
         EMIT_PEND_CUT: begin
            rsp_ref_ff    <= IDX_W'(pend_ff);
            rsp_found_ff  <= 1'b1;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= ST_TRUNCATED;
         end
         default: begin
            rsp_ref_ff    <= rsp_ref_ff;
            rsp_found_ff  <= rsp_found_ff;
            rsp_last_ff   <= rsp_last_ff;
            rsp_status_ff <= rsp_status_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_ref    = rsp_ref_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      stat            = '0;
      stat.in_valid   = req_tvalid;
      stat.in_mode    = mode_type'(req_tuser);
      stat.is_query   = (mode_ff == MODE_QUERY);
      stat.store_full = (count_ff >= CW'(MAX_POINTS));
      stat.bad_index  = (32'(q_ff) >= 32'(count_ff));
      stat.tab_valid  = tab_rvalid_ff;
      stat.tab_match  = (tab_rkey_ff == key_ff);
      stat.probe_last = (pcnt_ff == TW'(TABLE_SIZE - 1));
      stat.axis_last  = (axis_ff == 2'd2);
      stat.cell_last  = (dx_ff == 2'd2) && (dy_ff == 2'd2) && (dz_ff == 2'd2);
      stat.node_end   = (node_ff == LINK_END);
      stat.node_is_q  = (node_ff == CW'(q_ff));
      stat.n_zero     = (n_ff == '0);
      stat.n_full     = (n_ff == NW'(MAX_NEIGHBOURS));
      stat.out_free   = !rsp_valid_ff || rsp_tready;
      stat.sweep_last = (sweep_ff == TW'(TABLE_SIZE - 1));
   end

endmodule

`default_nettype wire

// ===== hw/rtl/spatial_hash_neighbour_search_top.sv =====
// Uniform grid neighbour search. One item is handled at a time. An insert hashes
// its cell key and linearly probes the cell table (one table read port, one read
// a probe); an insert into a full point store is answered without probing.
// A query probes the table for each of the 27 cells around the cell of the query
// point and walks the list of each cell it finds (one link memory read per
// entry), and it stalls while the result register is full.
// After reset and after a clear item the cell table is swept with the input held
// off. TABLE_SIZE must be a power of two.
`default_nettype none

module spatial_hash_neighbour_search_top
   import shns_pkg::*;
#(
   parameter int MAX_POINTS     = 1024,
   parameter int TABLE_SIZE     = 2048,
   parameter int MAX_NEIGHBOURS = 64,
   parameter int KEY_BITS       = 21
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // coord_x, coord_y, coord_z, query_index, zero fill
   input  wire logic [IN_DATA_W-1:0]  req_tdata,
   // mode
   input  wire logic [IN_USER_W-1:0]  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // point_ref, zero fill
   output logic      [OUT_DATA_W-1:0] rsp_tdata,
   // found, status
   output logic      [OUT_USER_W-1:0] rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   ctrl_cmd_type       cmd;
   ctrl_stat_type      stat;
   logic [SCALE_W-1:0] cell_scale;
   logic [IDX_W-1:0]   rsp_ref;
   logic               rsp_found;
   status_type         rsp_status;

   shns_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cell_scale  (cell_scale)
   );

   shns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .cmd        (cmd),
      .req_tready (req_tready)
   );

   shns_datapath #(
      .MAX_POINTS     (MAX_POINTS),
      .TABLE_SIZE     (TABLE_SIZE),
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
      .KEY_BITS       (KEY_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cell_scale (cell_scale),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_ref    (rsp_ref),
      .rsp_found  (rsp_found),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {{(OUT_DATA_W - IDX_W){1'b0}}, rsp_ref};
   assign rsp_tuser = {rsp_status, rsp_found};

endmodule

`default_nettype wire

// ===== hw/rtl/shns_checker.sv =====
// port checks on the result channel of the neighbour search block
`default_nettype none

`include "spatial_hash_neighbour_search_top_assert.svh"

module shns_checker
   import shns_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [OUT_DATA_W-1:0] rsp_tdata,
   input wire logic [OUT_USER_W-1:0] rsp_tuser,
   input wire logic                  rsp_tlast
);

   `SHNS_ASSERT(a_empty_item, clock, reset, (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tlast && rsp_tdata == '0), "empty item not last or ref nonzero")
   `SHNS_ASSERT(a_status_last, clock, reset, (rsp_tvalid && rsp_tuser[3:1] != ST_OK) |-> rsp_tlast, "status on an item that is not last")
   `SHNS_ASSERT_HOLD(a_hold_valid, clock, reset, rsp_tvalid, rsp_tready, rsp_tvalid)
   `SHNS_ASSERT_HOLD(a_hold_data, clock, reset, rsp_tvalid, rsp_tready, rsp_tdata)

endmodule

bind spatial_hash_neighbour_search_top shns_checker u_shns_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for the grid neighbour search block: predicted results versus the stream output
`timescale 1ns / 1ps
`default_nettype none

module tb_top
   import shns_pkg::*;
();

   localparam int N_POINTS   = 1024;
   localparam int N_SLOTS    = 2048;
   localparam int N_NEIGH    = 64;
   localparam int KB         = 21;
   localparam int STALL_MAX  = 200000;
   localparam int DRAIN_WAIT = 2300;

   typedef struct {
      logic [9:0] pref;
      bit         found;
      bit         last;
      status_type st;
   } hit_type;

   class neighbour_board;
      logic [23:0]   scale;
      int            point_count;
      logic [62:0]   point_key[N_POINTS];
      int            next_link[N_POINTS];
      bit            slot_used[N_SLOTS];
      logic [62:0]   slot_key[N_SLOTS];
      int            slot_head[N_SLOTS];
      hit_type       hits_due[$];
      int            errors;

      function new();
         scale = SCALE_RESET;
         point_count = 0;
         errors = 0;
         foreach (slot_used[i]) slot_used[i] = 0;
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      function logic [KB-1:0] axis_cell(logic [31:0] c);
         logic [63:0] mag;
         logic [63:0] q;
         mag = {32'd0, (c[31] ? -c : c)};
         q = (mag * {40'd0, scale}) >> 32;
         if (c[31]) q = -q;
         return q[KB-1:0];
      endfunction

      function int locate(logic [62:0] key, output int slot);
         logic [63:0] h;
         int s;
         h = ({43'd0, key[20:0]} * 64'd73856093) ^ ({43'd0, key[41:21]} * 64'd19349663)
             ^ ({43'd0, key[62:42]} * 64'd83492791);
         slot = 0;
         for (int i = 0; i < N_SLOTS; i++) begin
            s = (int'(h[10:0]) + i) % N_SLOTS;
            if (!slot_used[s]) begin
               slot = s;
               return 0;
            end
            if (slot_key[s] == key) begin
               slot = s;
               return 1;
            end
         end
         return -1;
      endfunction

      function void push(logic [9:0] p, bit f, bit l, status_type s);
         hit_type h;
         h.pref = p;
         h.found = f;
         h.last = l;
         h.st = s;
         hits_due.insert(hits_due.size(), h);
      endfunction

      function void note_item(mode_type mode, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [9:0] qi);
         logic [62:0] key;
         logic [KB-1:0] kx, ky, kz;
         int slot, r, n, node, steps;
         bit cut;
         case (mode)
            MODE_INSERT: begin
               if (point_count >= N_POINTS) begin
                  push(0, 0, 1, ST_STORE_FULL);
                  return;
               end
               key = {axis_cell(z), axis_cell(y), axis_cell(x)};
               r = locate(key, slot);
               if (r < 0) begin
                  push(0, 0, 1, ST_TABLE_FULL);
                  return;
               end
               if (r == 0) begin
                  slot_used[slot] = 1;
                  slot_key[slot] = key;
                  next_link[point_count] = N_POINTS;
               end else begin
                  next_link[point_count] = slot_head[slot];
               end
               slot_head[slot] = point_count;
               point_key[point_count] = key;
               push(point_count[9:0], 1, 1, ST_OK);
               point_count++;
            end
            MODE_QUERY: begin
               if (int'(qi) >= point_count) begin
                  push(0, 0, 1, ST_BAD_INDEX);
                  return;
               end
               key = point_key[qi];
               n = 0;
               cut = 0;
               for (int dz = -1; dz <= 1 && !cut; dz++)
                  for (int dy = -1; dy <= 1 && !cut; dy++)
                     for (int dx = -1; dx <= 1 && !cut; dx++) begin
                        kx = key[20:0] + KB'(dx);
                        ky = key[41:21] + KB'(dy);
                        kz = key[62:42] + KB'(dz);
                        if (locate({kz, ky, kx}, slot) != 1) continue;
                        node = slot_head[slot];
                        steps = 0;
                        while (node < N_POINTS && steps < N_POINTS) begin
                           if (node != int'(qi)) begin
                              if (n >= N_NEIGH) begin
                                 cut = 1;
                                 break;
                              end
                              push(node[9:0], 1, 0, ST_OK);
                              n++;
                           end
                           node = next_link[node];
                           steps++;
                        end
                     end
               if (n == 0) begin
                  push(0, 0, 1, ST_OK);
               end else begin
                  hits_due[$].last = 1;
                  if (cut) hits_due[$].st = ST_TRUNCATED;
               end
            end
            MODE_CLEAR: begin
               point_count = 0;
               foreach (slot_used[i]) slot_used[i] = 0;
               push(0, 0, 1, ST_OK);
            end
            default: ;
         endcase
      endfunction

      task check_result(logic [9:0] p, bit f, bit l, logic [2:0] s);
         hit_type h;
         if (hits_due.size() == 0) begin
            report($sformatf("unexpected item ref %0d found %0d last %0d status %0d",
                             p, f, l, s));
            return;
         end
         h = hits_due.pop_front();
         if (p !== h.pref) report($sformatf("point_ref %0d, want %0d", p, h.pref));
         if (f !== h.found) report($sformatf("found %0d, want %0d", f, h.found));
         if (l !== h.last) report($sformatf("last %0d, want %0d", l, h.last));
         if (s !== h.st) report($sformatf("status %0d, want %0d", s, h.st));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [IN_DATA_W-1:0] req_tdata = '0;
   logic [IN_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic [OUT_USER_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   neighbour_board board = new();
   bit idling = 1;
   int quiet_cycles = 0;

   spatial_hash_neighbour_search_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata[9:0], rsp_tuser[0], rsp_tlast, rsp_tuser[3:1]);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable) || reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_MAX) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (idling && $urandom_range(0, 9) == 0) begin
            rsp_tready = 0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_tready = 1;
      end
   end

   task send(mode_type mode, logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [9:0] qi);
      @(negedge clock);
      req_tvalid = 1;
      req_tuser = mode;
      req_tdata = {6'd0, qi, z, y, x};
      do @(posedge clock); while (!req_tready);
      board.note_item(mode, x, y, z, qi);
      if (idling && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_tvalid = 0;
         repeat ($urandom_range(0, 17)) @(negedge clock);
      end
   endtask

   task insert_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      send(MODE_INSERT, x, y, z, 0);
   endtask

   task query(logic [9:0] qi);
      send(MODE_QUERY, 0, 0, 0, qi);
   endtask

   task drain();
      @(negedge clock);
      req_tvalid = 0;
      while (board.hits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task write_scale(logic [23:0] value);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_paddr = {REG_CELL_SCALE, 2'b00};
      csr_pwdata = {8'd0, value};
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      board.scale = value;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   function logic [31:0] near_coord();
      int ip;
      ip = $urandom_range(0, 6) - 3;
      return {ip[15:0], 16'($urandom)};
   endfunction

   function logic [31:0] any_coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return near_coord();
   endfunction

   task random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         insert_at(any_coord(), any_coord(), any_coord());
      end else if (r < 88 && board.point_count > 0) begin
         query(10'($urandom_range(0, board.point_count - 1)));
      end else if (r < 90) begin
         send(MODE_CLEAR, 0, 0, 0, 0);
      end else if (r < 93) begin
         send(MODE_IGNORE, $urandom, $urandom, $urandom, 10'($urandom));
      end else begin
         query(10'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes at the reset scale
      query(0);
      send(MODE_IGNORE, '1, '1, '1, '1);
      insert_at(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
      insert_at(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
      insert_at(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      insert_at(32'h0001_0000, 32'hffff_0000, 32'h0000_ffff);
      insert_at(32'h0000_8000, 32'hffff_8000, 32'h0001_8000);
      insert_at(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      for (int i = 0; i < 6; i++) query(i[9:0]);
      query(10'd6);
      query(10'h3ff);
      send(MODE_CLEAR, 0, 0, 0, 0);
      query(0);
      drain();

      // every point in one cell: truncation
      write_scale(24'd0);
      for (int i = 0; i < 70; i++) insert_at($urandom, $urandom, $urandom);
      query(10'd5);
      query(10'd69);
      insert_at(0, 0, 0);
      query(10'h3ff);
      send(MODE_CLEAR, 0, 0, 0, 0);
      drain();

      write_scale(24'hff_ffff);
      for (int i = 0; i < 40; i++) random_item();
      drain();
      write_scale(24'($urandom_range(24'h00_4000, 24'h04_0000)));
      for (int i = 0; i < 60; i++) random_item();
      drain();
      write_scale(24'($urandom));
      for (int i = 0; i < 40; i++) random_item();
      drain();
      write_scale(SCALE_RESET);
      idling = 0;
      for (int i = 0; i < 80; i++) random_item();
      @(negedge clock);
      req_tvalid = 0;

      while (board.hits_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== spatial_hash_neighbour_search_top.f =====
+incdir+hw/rtl
hw/rtl/shns_pkg.sv
hw/rtl/shns_csr.sv
hw/rtl/shns_ctrl.sv
hw/rtl/shns_datapath.sv
hw/rtl/spatial_hash_neighbour_search_top.sv
hw/rtl/shns_checker.sv
verif/tb_top.sv
